>>> rtl/apt_pkg.sv
// Shared types and constants of the averaged power throttle block.
package apt_pkg;

    localparam int PW        = 21;
    localparam int CUR_W     = 15;
    localparam int PROD_W    = 31;
    localparam int RECIP_W   = 32;
    localparam int MUL_W     = PROD_W + RECIP_W;
    localparam int ADDR_W    = 4;
    localparam int CFG_W     = 16;

    localparam logic [12:0]        CUR_NUM   = 13'd6000;
    localparam int                 CUR_SH    = 10;
    localparam int                 PWR_SH    = 41;
    localparam logic [RECIP_W-1:0] PWR_RECIP = 32'd2199023256;

    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;

    localparam logic [CFG_W-1:0] LOW_RST  = 16'd4000;
    localparam logic [CFG_W-1:0] HIGH_RST = 16'd9000;
    localparam logic [CFG_W-1:0] GAIN_RST = 16'd7500;

    typedef struct packed {
        logic        cpu_active;
        logic [17:0] limit_mw;
        logic [15:0] bus_mv;
        logic [11:0] sense_mv;
        logic        sourcing;
    } t_in;

    typedef struct packed {
        logic          throttle_on;
        logic          throttle_changed;
        logic [PW-1:0] avg_power_mw;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] low_threshold_mw;
        logic [CFG_W-1:0] high_threshold_mw;
        logic [CFG_W-1:0] throttle_gain_mw;
    } t_cfg;

endpackage

>>> rtl/averaged_power_throttle_hysteresis.sv
// Top level of the averaged power throttle with hysteresis.
//
// One input word per monitoring tick enters on i_valid/o_ready and gives
// exactly one result word on o_valid/i_ready. The block works on one word
// at a time and o_ready is low while it does. A tick with the CPU inactive
// or with an unknown limit skips the measurement and goes straight to the
// threshold compare. A measured tick scales the sense voltage to a current,
// forms the power, divides it, sums the ring and divides that sum before
// the compare. The ring sum adds one stored reading per cycle; the shared
// reciprocal multiplier scales the power and then averages the ring.
// A finished word sits in an output register until it is taken, and the
// next word may be accepted meanwhile; if the receiver still stalls when
// that next word is done, the sequencer holds it until the register frees.
// Reset clears the reading ring, the write slot and the throttle state and
// loads the default thresholds. Thresholds are written over an APB-style
// port at byte addresses 0, 4 and 8; the user must write them only while
// the block is idle, as the block itself does not enforce this.
module averaged_power_throttle_hysteresis #(
    parameter int WINDOW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  apt_pkg::t_in               i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output apt_pkg::t_out              o_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [apt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import apt_pkg::*;

    localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = PW + $clog2(WINDOW) + 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_CUR  = 10'b0000000010,
        S_MUL  = 10'b0000000100,
        S_PGO  = 10'b0000001000,
        S_PDIV = 10'b0000010000,
        S_SUM  = 10'b0000100000,
        S_AGO  = 10'b0001000000,
        S_ADIV = 10'b0010000000,
        S_CMP  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_in               r_in;
    t_out              r_out;
    logic              r_out_valid;
    logic              r_thr;
    logic [PW-1:0]     r_ring [WINDOW];
    logic [IW-1:0]     r_slot;
    logic [IW-1:0]     r_cnt;
    logic [CUR_W-1:0]  r_cur;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_acc;
    logic [PW-1:0]     r_avg;

    t_cfg              w_cfg;
    logic              w_accept;
    logic              w_out_free;
    logic [24:0]       w_cur_full;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start;
    logic              w_div_avg;
    logic [PROD_W-1:0] w_div_num;
    logic              w_div_done;
    logic [PW-1:0]     w_div_quo;
    logic signed [23:0] w_gap;
    logic signed [23:0] w_gap_net;
    logic              w_keep;
    logic              w_begin;
    logic              w_new_thr;
    logic              w_last;

    apt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    apt_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_avg   (w_div_avg),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = (r_cnt == IW'(WINDOW - 1));

    assign w_cur_full = 25'(r_in.sense_mv) * 25'(CUR_NUM);
    assign w_prod     = PROD_W'(r_cur) * PROD_W'(r_in.bus_mv);

    assign w_div_start = (r_state == S_PGO) || (r_state == S_AGO);
    assign w_div_avg   = (r_state == S_AGO);
    assign w_div_num   = (r_state == S_PGO) ? r_prod : PROD_W'(r_acc);

    assign w_gap     = $signed({6'b0, r_in.limit_mw}) - $signed({3'b0, r_avg});
    assign w_gap_net = w_gap - $signed({8'b0, w_cfg.throttle_gain_mw});
    assign w_keep    = w_gap_net < $signed({8'b0, w_cfg.high_threshold_mw});
    assign w_begin   = w_gap < $signed({8'b0, w_cfg.low_threshold_mw});

    always_comb begin
        if (!r_in.cpu_active) begin
            w_new_thr = 1'b0;
        end else if (r_in.limit_mw == '0) begin
            w_new_thr = r_thr;
        end else if (r_in.sourcing) begin
            w_new_thr = r_thr ? w_keep : w_begin;
        end else begin
            w_new_thr = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_data.cpu_active || (i_data.limit_mw == '0)) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_CUR;
                    end
                end
            end
            S_CUR:  n_state = S_MUL;
            S_MUL:  n_state = S_PGO;
            S_PGO:  n_state = S_PDIV;
            S_PDIV: begin
                if (w_div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_last) begin
                    n_state = S_AGO;
                end
            end
            S_AGO:  n_state = S_ADIV;
            S_ADIV: begin
                if (w_div_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= 1'b0;
            r_slot      <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept && !i_data.cpu_active) begin
                r_ring[0] <= '0;
            end
            if ((r_state == S_PDIV) && w_div_done) begin
                if (r_ring[0] == '0) begin
                    for (int i = 0; i < WINDOW; i++) begin
                        r_ring[i] <= w_div_quo;
                    end
                end else begin
                    r_ring[r_slot] <= w_div_quo;
                end
                r_slot <= (r_slot == IW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_thr       <= w_new_thr;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in  <= i_data;
            r_avg <= '0;
        end
        if (r_state == S_CUR) begin
            r_cur <= w_cur_full[CUR_SH +: CUR_W];
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if ((r_state == S_PDIV) && w_div_done) begin
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_SUM) begin
            r_acc <= r_acc + SUM_W'(r_ring[r_cnt]);
            r_cnt <= r_cnt + 1'b1;
        end
        if ((r_state == S_ADIV) && w_div_done) begin
            r_avg <= w_div_quo;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.throttle_on      <= w_new_thr;
            r_out.throttle_changed <= w_new_thr ^ r_thr;
            r_out.avg_power_mw     <= r_avg;
        end
    end

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.throttle_on == r_thr))
        else $error("Held result word disagrees with the throttle state.");

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == S_PDIV) || (r_state == S_ADIV)))
        else $error("Divider finished outside a wait state.");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= IW'(WINDOW - 1))
        else $error("Ring write slot is out of range.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("Block stayed ready after taking a word.");

endmodule

>>> rtl/apt_cfg.sv
// Threshold and gain registers behind the APB-style configuration port.
module apt_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [apt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output apt_pkg::t_cfg             o_cfg
);
    import apt_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold_mw  <= LOW_RST;
            r_cfg.high_threshold_mw <= HIGH_RST;
            r_cfg.throttle_gain_mw  <= GAIN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LOW:  r_cfg.low_threshold_mw  <= pwdata[CFG_W-1:0];
                REG_HIGH: r_cfg.high_threshold_mw <= pwdata[CFG_W-1:0];
                REG_GAIN: r_cfg.throttle_gain_mw  <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LOW:  prdata = {16'b0, r_cfg.low_threshold_mw};
            REG_HIGH: prdata = {16'b0, r_cfg.high_threshold_mw};
            REG_GAIN: prdata = {16'b0, r_cfg.throttle_gain_mw};
            default:  prdata = 32'b0;
        endcase
    end

endmodule

>>> rtl/apt_div.sv
// Shared reciprocal multiplier that divides by the power scale or by the ring length.
module apt_div #(
    parameter int WINDOW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_avg,
    input  logic [apt_pkg::PROD_W-1:0] i_num,
    output logic                       o_done,
    output logic [apt_pkg::PW-1:0]     o_quo
);
    import apt_pkg::*;

    localparam int SUM_W  = PW + $clog2(WINDOW) + 1;
    localparam int AVG_SH = SUM_W + $clog2(WINDOW);
    localparam longint unsigned AVG_RECIP_L =
        ((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);

    logic               r_done;
    logic               r_sel_avg;
    logic [MUL_W-1:0]   r_prod;
    logic [RECIP_W-1:0] w_recip;

    assign w_recip = i_avg ? AVG_RECIP : PWR_RECIP;
    assign o_done  = r_done;
    assign o_quo   = r_sel_avg ? r_prod[AVG_SH +: PW] : r_prod[PWR_SH +: PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sel_avg <= i_avg;
            r_prod    <= MUL_W'(i_num) * MUL_W'(w_recip);
        end
    end

endmodule
